/* rtl/core/ppqs_pkg.sv */
// ppqs_pkg: shared widths, constants, configuration and command/status types
// for the pulse period qualifier. No dependencies.
`timescale 1ns / 1ps

package ppqs_pkg;

    localparam int TICK_W = 32;
    localparam int IV_W   = 24;
    localparam int CNT_W  = 16;
    localparam int FAC_W  = 16;
    localparam int SUM_W  = 40;
    localparam int SQ_W   = 64;
    localparam int MUL_W  = 32;
    localparam int PROD_W = 64;
    localparam int NUM_W  = 80;
    localparam int DIVR_W = 32;
    localparam int ROOT_W = 24;
    localparam int RAD_W  = 64;

    localparam int DIV_STEPS  = NUM_W;
    localparam int DIV_CW     = $clog2(DIV_STEPS);
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int SQRT_CW    = $clog2(SQRT_STEPS);

    localparam logic [CNT_W-1:0] MAX_PERIODS = 16'hFFFF;
    localparam logic [IV_W-1:0]  IV_SAT      = 24'hFF_FFFF;
    localparam logic [FAC_W-1:0] FAC_ONE     = 16'd256;
    localparam logic [FAC_W-1:0] FAC_RESET   = 16'd333;

    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    localparam logic [2:0] REG_MIN_PERIOD   = 3'd0;
    localparam logic [2:0] REG_MAX_PERIOD   = 3'd1;
    localparam logic [2:0] REG_MAX_FACTOR   = 3'd2;
    localparam logic [2:0] REG_WINDOW_START = 3'd3;
    localparam logic [2:0] REG_WINDOW_END   = 3'd4;

    typedef struct packed {
        logic [IV_W-1:0]   min_period;
        logic [IV_W-1:0]   max_period;
        logic [FAC_W-1:0]  max_factor_q8;
        logic [TICK_W-1:0] window_start;
        logic [TICK_W-1:0] window_end;
    } cfg_t;

    typedef enum logic [3:0] {
        MUL_HOLD,
        MUL_RATIO_E,
        MUL_RATIO_N,
        MUL_SQ_PEND,
        MUL_SQ_D,
        MUL_N_S2LO,
        MUL_N_S2HI,
        MUL_SLO_SLO,
        MUL_SLO_SHI,
        MUL_SHI_SHI,
        MUL_N_NM1
    } mul_sel_t;

    typedef enum logic [2:0] {
        NUM_HOLD,
        NUM_CLEAR,
        NUM_ADD_LO,
        NUM_ADD_MID,
        NUM_SUB_LO,
        NUM_SUB_MID2,
        NUM_SUB_HI
    } num_op_t;

    typedef struct packed {
        logic     load_in;
        logic     calc;
        logic     ratio_cap;
        logic     judge;
        logic     acc_a;
        logic     acc_b;
        mul_sel_t mul_sel;
        num_op_t  num_op;
        logic     nn1_load;
        logic     div_start;
        logic     div_sel;
        logic     mean_load;
        logic     sqrt_start;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } sts_t;

endpackage

/* rtl/core/ppqs_div.sv */
// ppqs_div: restoring divider, one quotient bit per cycle.
// Depends on ppqs_pkg.
`timescale 1ns / 1ps

module ppqs_div
    import ppqs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  dividend,
    input  logic [DIVR_W-1:0] divisor,
    output logic              done,
    output logic [NUM_W-1:0]  quotient
);

    logic [NUM_W-1:0]  work_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] dvs_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIVR_W:0]   rem_sh;
    logic              ge;
    logic [DIVR_W-1:0] rem_next;

    assign rem_sh   = {rem_reg, work_reg[NUM_W-1]};
    assign ge       = rem_sh >= {1'b0, dvs_reg};
    assign rem_next = ge ? DIVR_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DIVR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == DIV_CW'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            work_reg <= {work_reg[NUM_W-2:0], ge};
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

/* rtl/core/ppqs_sqrt.sv */
// ppqs_sqrt: bit-pair integer square root, one result bit per cycle.
// Depends on ppqs_pkg.
`timescale 1ns / 1ps

module ppqs_sqrt
    import ppqs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [RAD_W-1:0]   v_reg;
    logic [RAD_W-1:0]   r_reg;
    logic [RAD_W-1:0]   bit_reg;
    logic [SQRT_CW-1:0] cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [RAD_W-1:0] trial;
    logic             fits;

    assign trial = r_reg + bit_reg;
    assign fits  = v_reg >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == SQRT_CW'(SQRT_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= {2'b01, {(RAD_W-2){1'b0}}};
        end else if (busy_reg) begin
            if (fits) begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[ROOT_W-1:0];

endmodule

/* rtl/core/ppqs_ctrl.sv */
// ppqs_ctrl: sequencer for per-word judging and the end-of-set summary.
// Depends on ppqs_pkg; drives the datapath through cmd_t, reads sts_t.
`timescale 1ns / 1ps

module ppqs_ctrl
    import ppqs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [19:0] {
        ST_IDLE       = 20'h00001,
        ST_CALC       = 20'h00002,
        ST_RAT_E      = 20'h00004,
        ST_RAT_N      = 20'h00008,
        ST_JUDGE      = 20'h00010,
        ST_SQ_A       = 20'h00020,
        ST_ADD_A      = 20'h00040,
        ST_ADD_B      = 20'h00080,
        ST_V0         = 20'h00100,
        ST_V1         = 20'h00200,
        ST_V2         = 20'h00400,
        ST_V3         = 20'h00800,
        ST_V4         = 20'h01000,
        ST_V5         = 20'h02000,
        ST_NN1        = 20'h04000,
        ST_MEAN_WAIT  = 20'h08000,
        ST_VAR_START  = 20'h10000,
        ST_VAR_WAIT   = 20'h20000,
        ST_SQRT_WAIT  = 20'h40000,
        ST_OUT        = 20'h80000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        cmd.mul_sel = MUL_HOLD;
        cmd.num_op  = NUM_HOLD;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_RAT_E;
            end
            ST_RAT_E: begin
                cmd.mul_sel = MUL_RATIO_E;
                state_next  = ST_RAT_N;
            end
            ST_RAT_N: begin
                cmd.ratio_cap = 1'b1;
                cmd.mul_sel   = MUL_RATIO_N;
                state_next    = ST_JUDGE;
            end
            ST_JUDGE: begin
                cmd.judge  = 1'b1;
                state_next = ST_SQ_A;
            end
            ST_SQ_A: begin
                cmd.mul_sel = MUL_SQ_PEND;
                state_next  = ST_ADD_A;
            end
            ST_ADD_A: begin
                cmd.acc_a   = 1'b1;
                cmd.mul_sel = MUL_SQ_D;
                state_next  = ST_ADD_B;
            end
            ST_ADD_B: begin
                cmd.acc_b  = 1'b1;
                state_next = sts.last ? ST_V0 : ST_IDLE;
            end
            ST_V0: begin
                cmd.mul_sel = MUL_N_S2LO;
                cmd.num_op  = NUM_CLEAR;
                state_next  = ST_V1;
            end
            ST_V1: begin
                cmd.mul_sel = MUL_N_S2HI;
                cmd.num_op  = NUM_ADD_LO;
                state_next  = ST_V2;
            end
            ST_V2: begin
                cmd.mul_sel = MUL_SLO_SLO;
                cmd.num_op  = NUM_ADD_MID;
                state_next  = ST_V3;
            end
            ST_V3: begin
                cmd.mul_sel = MUL_SLO_SHI;
                cmd.num_op  = NUM_SUB_LO;
                state_next  = ST_V4;
            end
            ST_V4: begin
                cmd.mul_sel = MUL_SHI_SHI;
                cmd.num_op  = NUM_SUB_MID2;
                state_next  = ST_V5;
            end
            ST_V5: begin
                cmd.mul_sel = MUL_N_NM1;
                cmd.num_op  = NUM_SUB_HI;
                state_next  = ST_NN1;
            end
            ST_NN1: begin
                cmd.nn1_load  = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b0;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (sts.div_done) begin
                    cmd.mean_load = 1'b1;
                    state_next    = ST_VAR_START;
                end
            end
            ST_VAR_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_VAR_WAIT;
            end
            ST_VAR_WAIT: begin
                if (sts.div_done) begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT_WAIT;
                end
            end
            ST_SQRT_WAIT: begin
                if (sts.sqrt_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/ppqs_dp.sv */
// ppqs_dp: interval capture, period judging, running sums, summary arithmetic
// and result register. Depends on ppqs_pkg, ppqs_div and ppqs_sqrt.
`timescale 1ns / 1ps

module ppqs_dp
    import ppqs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [TICK_W-1:0] s_time_tick,
    input  logic              s_last_point,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CNT_W-1:0]  m_period_count,
    output logic [IV_W-1:0]   m_mean_period,
    output logic [IV_W-1:0]   m_stdev_period,
    output logic              m_mean_valid,
    output logic              m_stdev_valid
);

    // set state
    logic [TICK_W-1:0] newest_reg;
    logic              niw_reg;
    logic [IV_W-1:0]   earl_reg;
    logic [IV_W-1:0]   pend_reg;
    logic              pcnt_reg;
    logic [1:0]        ps_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SQ_W-1:0]   sqsum_reg;

    // per-word working registers
    logic [TICK_W-1:0] t_reg;
    logic              last_reg;
    logic [IV_W-1:0]   d_reg;
    logic              inwin_reg;
    logic              cntd_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              ex_e_reg;
    logic              acc_a_reg;
    logic              acc_b_reg;

    // summary registers
    logic [NUM_W-1:0]  num_reg;
    logic [DIVR_W-1:0] nn1_reg;
    logic [IV_W-1:0]   mean_reg;

    logic              m_valid_reg;
    logic [CNT_W-1:0]  m_count_reg;
    logic [IV_W-1:0]   m_mean_reg;
    logic [IV_W-1:0]   m_stdev_reg;
    logic              m_mvalid_reg;
    logic              m_svalid_reg;

    logic              inwin_c;
    logic [TICK_W-1:0] diff;
    logic [IV_W-1:0]   d_c;
    logic [IV_W-1:0]   big_e, small_e, big_n, small_n;
    logic              ex_n;
    logic              eq_lim;
    logic              pend_rng, d_rng, nbr_ok;
    logic              acc_a_c, acc_b_c;
    logic              count_full;
    logic              acc_go;
    logic [IV_W-1:0]   acc_iv;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod_c;
    logic [NUM_W-1:0]  num_term;
    logic [NUM_W-1:0]  div_dividend;
    logic [DIVR_W-1:0] div_divisor;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;

    assign inwin_c = (cfg.window_end <= cfg.window_start) ||
                     ((t_reg >= cfg.window_start) && (t_reg <= cfg.window_end));
    assign diff    = t_reg - newest_reg;
    assign d_c     = (t_reg > newest_reg) ? ((|diff[TICK_W-1:IV_W]) ? IV_SAT : diff[IV_W-1:0])
                                          : '0;

    assign big_e   = (pend_reg > earl_reg) ? pend_reg : earl_reg;
    assign small_e = (pend_reg > earl_reg) ? earl_reg : pend_reg;
    assign big_n   = (pend_reg > d_reg) ? pend_reg : d_reg;
    assign small_n = (pend_reg > d_reg) ? d_reg : pend_reg;
    assign ex_n    = {32'd0, big_n, 8'd0} > prod_reg;

    assign eq_lim   = cfg.min_period == cfg.max_period;
    assign pend_rng = (pend_reg != '0) && (pend_reg >= cfg.min_period) &&
                      (pend_reg <= cfg.max_period);
    assign d_rng    = (d_reg != '0) && (d_reg >= cfg.min_period) && (d_reg <= cfg.max_period);
    assign nbr_ok   = (cfg.max_factor_q8 < FAC_ONE) || (ps_reg != 2'd3) ||
                      (earl_reg == '0) || (d_reg == '0) || !(ex_e_reg && ex_n);
    assign acc_a_c  = (ps_reg >= 2'd2) && pcnt_reg && (eq_lim || (pend_rng && nbr_ok));
    assign acc_b_c  = (ps_reg != 2'd0) && last_reg && cntd_reg && (eq_lim || d_rng);

    assign count_full = count_reg == MAX_PERIODS;
    assign acc_go     = (cmd.acc_a && acc_a_reg) || (cmd.acc_b && acc_b_reg);
    assign acc_iv     = cmd.acc_b ? d_reg : pend_reg;

    // shared 32x32 multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_RATIO_E: begin
                mul_a = {16'd0, cfg.max_factor_q8};
                mul_b = {8'd0, small_e};
            end
            MUL_RATIO_N: begin
                mul_a = {16'd0, cfg.max_factor_q8};
                mul_b = {8'd0, small_n};
            end
            MUL_SQ_PEND: begin
                mul_a = {8'd0, pend_reg};
                mul_b = {8'd0, pend_reg};
            end
            MUL_SQ_D: begin
                mul_a = {8'd0, d_reg};
                mul_b = {8'd0, d_reg};
            end
            MUL_N_S2LO: begin
                mul_a = {16'd0, count_reg};
                mul_b = sqsum_reg[31:0];
            end
            MUL_N_S2HI: begin
                mul_a = {16'd0, count_reg};
                mul_b = sqsum_reg[63:32];
            end
            MUL_SLO_SLO: begin
                mul_a = sum_reg[31:0];
                mul_b = sum_reg[31:0];
            end
            MUL_SLO_SHI: begin
                mul_a = sum_reg[31:0];
                mul_b = {24'd0, sum_reg[39:32]};
            end
            MUL_SHI_SHI: begin
                mul_a = {24'd0, sum_reg[39:32]};
                mul_b = {24'd0, sum_reg[39:32]};
            end
            MUL_N_NM1: begin
                mul_a = {16'd0, count_reg};
                mul_b = {16'd0, CNT_W'(count_reg - 1'b1)};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c = mul_a * mul_b;

    // n*S2 - S*S built from partial products
    always_comb begin
        case (cmd.num_op)
            NUM_ADD_LO, NUM_SUB_LO: num_term = {16'd0, prod_reg};
            NUM_ADD_MID:            num_term = {prod_reg[47:0], 32'd0};
            NUM_SUB_MID2:           num_term = {prod_reg[46:0], 33'd0};
            NUM_SUB_HI:             num_term = {prod_reg[15:0], 64'd0};
            default:                num_term = '0;
        endcase
    end

    assign div_dividend = cmd.div_sel ? num_reg : {40'd0, sum_reg};
    assign div_divisor  = cmd.div_sel ? nn1_reg : {16'd0, count_reg};

    ppqs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    ppqs_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (div_quot[RAD_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newest_reg  <= '0;
            niw_reg     <= 1'b0;
            earl_reg    <= '0;
            pend_reg    <= '0;
            pcnt_reg    <= 1'b0;
            ps_reg      <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            sqsum_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (acc_go && !count_full) begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + {16'd0, acc_iv};
                sqsum_reg <= sqsum_reg + prod_reg;
            end
            if (cmd.acc_b) begin
                if (ps_reg != 2'd0) begin
                    earl_reg <= pend_reg;
                    pend_reg <= d_reg;
                    pcnt_reg <= cntd_reg;
                end
                newest_reg <= t_reg;
                niw_reg    <= inwin_reg;
                ps_reg     <= (ps_reg == 2'd3) ? 2'd3 : ps_reg + 2'd1;
            end
            if (cmd.out_load) begin
                newest_reg  <= '0;
                niw_reg     <= 1'b0;
                earl_reg    <= '0;
                pend_reg    <= '0;
                pcnt_reg    <= 1'b0;
                ps_reg      <= '0;
                count_reg   <= '0;
                sum_reg     <= '0;
                sqsum_reg   <= '0;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            t_reg    <= s_time_tick;
            last_reg <= s_last_point;
        end
        if (cmd.calc) begin
            d_reg     <= d_c;
            inwin_reg <= inwin_c;
            cntd_reg  <= niw_reg && inwin_c;
        end
        if (cmd.mul_sel != MUL_HOLD) begin
            prod_reg <= prod_c;
        end
        if (cmd.ratio_cap) begin
            ex_e_reg <= {32'd0, big_e, 8'd0} > prod_reg;
        end
        if (cmd.judge) begin
            acc_a_reg <= acc_a_c;
            acc_b_reg <= acc_b_c;
        end
        case (cmd.num_op)
            NUM_CLEAR:                           num_reg <= '0;
            NUM_ADD_LO, NUM_ADD_MID:             num_reg <= num_reg + num_term;
            NUM_SUB_LO, NUM_SUB_MID2, NUM_SUB_HI: num_reg <= num_reg - num_term;
            default:                             num_reg <= num_reg;
        endcase
        if (cmd.nn1_load) begin
            nn1_reg <= prod_reg[DIVR_W-1:0];
        end
        if (cmd.mean_load) begin
            mean_reg <= div_quot[IV_W-1:0];
        end
        if (cmd.out_load) begin
            m_count_reg  <= count_reg;
            m_mean_reg   <= (count_reg != '0) ? mean_reg : '0;
            m_stdev_reg  <= (count_reg >= CNT_W'(2)) ? sqrt_root : '0;
            m_mvalid_reg <= count_reg != '0;
            m_svalid_reg <= count_reg >= CNT_W'(2);
        end
    end

    assign sts.last      = last_reg;
    assign sts.div_done  = div_done;
    assign sts.sqrt_done = sqrt_done;
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_period_count = m_count_reg;
    assign m_mean_period  = m_mean_reg;
    assign m_stdev_period = m_stdev_reg;
    assign m_mean_valid   = m_mvalid_reg;
    assign m_stdev_valid  = m_svalid_reg;

endmodule

/* rtl/core/pulse_period_qualifier_stats.sv */
// pulse_period_qualifier_stats: top level with configuration registers,
// sequencer and datapath. Depends on ppqs_pkg, ppqs_ctrl and ppqs_dp.
// Each word occupies the block from acceptance until its sums are updated (one shared
// multiplier walks the ratio tests and the squaring); the last word of a set adds a
// summary (partial products, two 80-step divisions, a 32-step root), and its result
// then waits in an output register; the next word is taken once it is stored.
// Synchronous active-low reset clears the set and loads the register defaults.
`timescale 1ns / 1ps

module pulse_period_qualifier_stats
    import ppqs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [TICK_W-1:0] s_time_tick,
    input  logic              s_last_point,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CNT_W-1:0]  m_period_count,
    output logic [IV_W-1:0]   m_mean_period,
    output logic [IV_W-1:0]   m_stdev_period,
    output logic              m_mean_valid,
    output logic              m_stdev_valid
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;
    cmd_t       cmd;
    sts_t       sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_period    <= '0;
            cfg_reg.max_period    <= '0;
            cfg_reg.max_factor_q8 <= FAC_RESET;
            cfg_reg.window_start  <= '0;
            cfg_reg.window_end    <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MIN_PERIOD:   cfg_reg.min_period    <= pwdata[IV_W-1:0];
                REG_MAX_PERIOD:   cfg_reg.max_period    <= pwdata[IV_W-1:0];
                REG_MAX_FACTOR:   cfg_reg.max_factor_q8 <= pwdata[FAC_W-1:0];
                REG_WINDOW_START: cfg_reg.window_start  <= pwdata;
                REG_WINDOW_END:   cfg_reg.window_end    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_PERIOD:   prdata = {8'd0, cfg_reg.min_period};
            REG_MAX_PERIOD:   prdata = {8'd0, cfg_reg.max_period};
            REG_MAX_FACTOR:   prdata = {16'd0, cfg_reg.max_factor_q8};
            REG_WINDOW_START: prdata = cfg_reg.window_start;
            REG_WINDOW_END:   prdata = cfg_reg.window_end;
            default:          prdata = '0;
        endcase
    end

    ppqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ppqs_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .sts            (sts),
        .s_time_tick    (s_time_tick),
        .s_last_point   (s_last_point),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_period_count (m_period_count),
        .m_mean_period  (m_mean_period),
        .m_stdev_period (m_stdev_period),
        .m_mean_valid   (m_mean_valid),
        .m_stdev_valid  (m_stdev_valid)
    );

endmodule
